// ===== design/fp32_asm_pkg.sv =====
// ----------------------------------------------------------------------------
// fp32_asm_pkg
// Shared constants for the single-precision add/subtract/multiply unit.
// ----------------------------------------------------------------------------
package fp32_asm_pkg;
	localparam logic [7:0]  EXP_BIAS  = 8'd127;
	localparam logic [7:0]  EXP_MAX   = 8'hFF;
	localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
	localparam logic [1:0]  OP_ADD    = 2'd0;
	localparam logic [1:0]  OP_SUB    = 2'd1;
	localparam logic [1:0]  OP_MUL    = 2'd2;
	localparam logic [1:0]  OP_MUL_ALT = 2'd3;

	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
	} spec_t;
endpackage

// ===== design/fp32_add_sub_mul_unit_top.sv =====
// ----------------------------------------------------------------------------
// fp32_add_sub_mul_unit_top
// Pipelined IEEE single-precision add, subtract and multiply, truncating.
// ----------------------------------------------------------------------------
// Input channel: valid/ready with op, operand_a, operand_b.
// Output channel: valid/ready with result_bits, overflow, underflow.
// op 0 adds, 1 subtracts (a - b), 2 and 3 multiply.
// out_valid rises once the result is held in the stage 4 register; one
// operation is accepted every cycle while the output is taken.
// Stage 1 unpacks, orders operands, flags special values and forms the
// significand product; stage 2 aligns and adds; stage 3 finds the leading
// one; stage 4 normalizes, packs and holds the result for the receiver.
// Subnormal inputs read as zero; results round toward zero; exponent
// overflow saturates to infinity and underflow flushes to zero, flagged.
// A stall at the output holds the last stage; earlier stages keep advancing
// into empty slots, and ready falls only while the last stage holds an
// untaken result and every stage is occupied.
// Reset clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module fp32_add_sub_mul_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_bits,
	output logic        overflow,
	output logic        underflow
);
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv4, adv3, adv2, adv1;

	assign adv4 = !v_s4 || out_ready;
	assign adv3 = adv4 || !v_s3;
	assign adv2 = adv3 || !v_s2;
	assign adv1 = adv2 || !v_s1;
	assign in_ready = adv1;

	// stage 1 combinational
	logic        sa, sb, ismul;
	logic [7:0]  ea, eb;
	logic [22:0] fa, fb;
	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic        swap;
	fp32_asm_pkg::spec_t spec_c;

	always_comb begin
		ismul  = op[1];
		sa     = operand_a[31];
		ea     = operand_a[30:23];
		fa     = operand_a[22:0];
		sb     = operand_b[31] ^ (!op[1] & op[0]);
		eb     = operand_b[30:23];
		fb     = operand_b[22:0];
		nan_a  = (ea == fp32_asm_pkg::EXP_MAX) && (fa != '0);
		nan_b  = (eb == fp32_asm_pkg::EXP_MAX) && (fb != '0);
		inf_a  = (ea == fp32_asm_pkg::EXP_MAX) && (fa == '0);
		inf_b  = (eb == fp32_asm_pkg::EXP_MAX) && (fb == '0);
		zero_a = (ea == '0);
		zero_b = (eb == '0);
		swap   = {ea, fa} < {eb, fb};
		spec_c = '{special: 1'b0, special_bits: 32'h0};
		if (ismul) begin
			if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
				spec_c = '{1'b1, fp32_asm_pkg::QNAN_BITS};
			else if (inf_a || inf_b)
				spec_c = '{1'b1, {sa ^ sb, fp32_asm_pkg::EXP_MAX, 23'h0}};
			else if (zero_a || zero_b)
				spec_c = '{1'b1, {sa ^ sb, 31'h0}};
		end else begin
			if (nan_a || nan_b || (inf_a && inf_b && (sa != sb)))
				spec_c = '{1'b1, fp32_asm_pkg::QNAN_BITS};
			else if (inf_a)
				spec_c = '{1'b1, {sa, fp32_asm_pkg::EXP_MAX, 23'h0}};
			else if (inf_b)
				spec_c = '{1'b1, {sb, fp32_asm_pkg::EXP_MAX, 23'h0}};
			else if (zero_a && zero_b)
				spec_c = '{1'b1, {sa & sb, 31'h0}};
			else if (zero_b)
				spec_c = '{1'b1, {sa, ea, fa}};
			else if (zero_a)
				spec_c = '{1'b1, {sb, eb, fb}};
		end
	end

	logic                 mul_s1;
	fp32_asm_pkg::spec_t  spec_s1;
	logic                 sx_s1, sy_s1;
	logic [7:0]           ex_s1, ey_s1;
	logic [23:0]          mx_s1, my_s1;
	logic [47:0]          prod_s1;
	logic signed [9:0]    pe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			mul_s1  <= ismul;
			spec_s1 <= spec_c;
			sx_s1   <= swap ? sb : sa;
			sy_s1   <= swap ? sa : sb;
			ex_s1   <= swap ? eb : ea;
			ey_s1   <= swap ? ea : eb;
			mx_s1   <= swap ? {1'b1, fb} : {1'b1, fa};
			my_s1   <= swap ? {1'b1, fa} : {1'b1, fb};
			prod_s1 <= 48'({1'b1, fa}) * 48'({1'b1, fb});
			pe_s1   <= $signed({2'b00, ea}) + $signed({2'b00, eb})
				- $signed({2'b00, fp32_asm_pkg::EXP_BIAS});
		end
	end

	// stage 2: align and add; sum has leading bit at 47 or 48 (add) or lower
	logic [7:0]  d;
	logic [47:0] big, small_sh, lost_mask;
	logic [48:0] sum_c;

	always_comb begin
		d         = ex_s1 - ey_s1;
		big       = {mx_s1, 24'h0};
		lost_mask = '0;
		small_sh  = '0;
		if (d >= 8'd48) begin
			small_sh = 48'h1;
		end else begin
			lost_mask = (48'h1 << d[5:0]) - 48'h1;
			small_sh  = {my_s1, 24'h0} >> d[5:0];
			if (({my_s1, 24'h0} & lost_mask) != '0)
				small_sh[0] = 1'b1;
		end
		if (sx_s1 == sy_s1)
			sum_c = {1'b0, big} + {1'b0, small_sh};
		else
			sum_c = {1'b0, big} - {1'b0, small_sh};
	end

	fp32_asm_pkg::spec_t spec_s2;
	logic               s_s2, mul_s2;
	logic [48:0]        sig_s2;
	logic signed [9:0]  e_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			spec_s2 <= spec_s1;
			mul_s2  <= mul_s1;
			s_s2    <= mul_s1 ? (sx_s1 ^ sy_s1) : sx_s1;
			sig_s2  <= mul_s1 ? {1'b0, prod_s1} : sum_c;
			e_s2    <= mul_s1 ? pe_s1 : $signed({2'b00, ex_s1});
		end
	end

	// stage 3: leading one search
	logic [5:0] lz_c;

	always_comb begin
		lz_c = '0;
		for (int i = 0; i < 49; i++)
			if (sig_s2[i]) lz_c = 6'(i);
	end

	fp32_asm_pkg::spec_t spec_s3;
	logic               s_s3, mul_s3, zsum_s3;
	logic [48:0]        sig_s3;
	logic signed [9:0]  e_s3;
	logic [5:0]         p_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			spec_s3 <= spec_s2;
			s_s3    <= s_s2;
			mul_s3  <= mul_s2;
			zsum_s3 <= (sig_s2 == '0);
			sig_s3  <= sig_s2;
			e_s3    <= e_s2;
			p_s3    <= lz_c;
		end
	end

	// stage 4: normalize, pack
	logic signed [9:0] en_c;
	logic [48:0]       nsig;
	logic [31:0]       res_c;
	logic              ovf_c, unf_c;

	always_comb begin
		en_c  = e_s3 + $signed({4'b0, p_s3}) - (mul_s3 ? 10'sd46 : 10'sd47);
		nsig  = sig_s3 << (6'd48 - p_s3);
		ovf_c = 1'b0;
		unf_c = 1'b0;
		if (spec_s3.special) begin
			res_c = spec_s3.special_bits;
		end else if (!mul_s3 && zsum_s3) begin
			res_c = 32'h0;
		end else if (en_c >= 10'sd255) begin
			res_c = {s_s3, fp32_asm_pkg::EXP_MAX, 23'h0};
			ovf_c = 1'b1;
		end else if (en_c <= 10'sd0) begin
			res_c = {s_s3, 31'h0};
			unf_c = 1'b1;
		end else begin
			res_c = {s_s3, en_c[7:0], nsig[47:25]};
		end
	end

	logic [31:0] res_s4;
	logic        ovf_s4, unf_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			res_s4 <= res_c;
			ovf_s4 <= ovf_c;
			unf_s4 <= unf_c;
		end
	end

	assign out_valid   = v_s4;
	assign result_bits = res_s4;
	assign overflow    = ovf_s4;
	assign underflow   = unf_s4;

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(overflow && underflow))
		else $error("overflow and underflow both set");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_bits))
		else $error("stalled result changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && !out_ready)
		else $error("ready low without full stall");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> result_bits[30:0] == 31'h7F800000)
		else $error("overflow without infinity");
endmodule

// ===== bench/fp32_add_sub_mul_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp32_add_sub_mul_checker
// Watches both channels of the add/subtract/multiply unit, computes the
// expected truncated single-precision result of every accepted operation and
// compares each delivered result field by field, in order.
// ----------------------------------------------------------------------------
module fp32_add_sub_mul_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] result_bits,
	input  logic        overflow,
	input  logic        underflow,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [31:0] bits;
		logic        ovf;
		logic        unf;
	} fp_result_t;

	fp_result_t expected_results[$];

	function automatic int lead_pos(logic [63:0] v);
		int p;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (v[i])
				p = i;
		return p;
	endfunction

	function automatic fp_result_t normalize(logic s, int e_base, logic [63:0] sig, int ref_pos);
		fp_result_t r;
		int p;
		int e;
		logic [22:0] frac;
		p = lead_pos(sig);
		e = e_base + p - ref_pos;
		frac = (p >= 23) ? 23'(sig >> (p - 23)) : 23'(sig << (23 - p));
		r = '0;
		if (e >= 255) begin
			r.bits = {s, fp32_asm_pkg::EXP_MAX, 23'd0};
			r.ovf = 1'b1;
		end else if (e <= 0) begin
			r.bits = {s, 31'd0};
			r.unf = 1'b1;
		end else begin
			r.bits = {s, 8'(e), frac};
		end
		return r;
	endfunction

	function automatic fp_result_t fp_compute(logic [1:0] code, logic [31:0] a, logic [31:0] b);
		fp_result_t r;
		logic sa, sb, s, sx, sy, t;
		logic [7:0] ea, eb, ex, ey, te;
		logic [23:0] mx, my, tm;
		logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
		logic [63:0] big, sml, sum, lost;
		int d;
		sa = a[31]; ea = a[30:23];
		sb = b[31]; eb = b[30:23];
		nan_a = (ea == fp32_asm_pkg::EXP_MAX) && (a[22:0] != 0);
		nan_b = (eb == fp32_asm_pkg::EXP_MAX) && (b[22:0] != 0);
		inf_a = (ea == fp32_asm_pkg::EXP_MAX) && (a[22:0] == 0);
		inf_b = (eb == fp32_asm_pkg::EXP_MAX) && (b[22:0] == 0);
		zero_a = (ea == 0);
		zero_b = (eb == 0);
		r = '0;
		if (code[1]) begin
			s = sa ^ sb;
			if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
				r.bits = fp32_asm_pkg::QNAN_BITS;
			else if (inf_a || inf_b)
				r.bits = {s, fp32_asm_pkg::EXP_MAX, 23'd0};
			else if (zero_a || zero_b)
				r.bits = {s, 31'd0};
			else
				r = normalize(s,
					int'(ea) + int'(eb) - int'(fp32_asm_pkg::EXP_BIAS),
					64'({1'b1, a[22:0]}) * 64'({1'b1, b[22:0]}), 46);
			return r;
		end
		sb = sb ^ (code == fp32_asm_pkg::OP_SUB);
		if (nan_a || nan_b || (inf_a && inf_b && sa != sb))
			r.bits = fp32_asm_pkg::QNAN_BITS;
		else if (inf_a)
			r.bits = {sa, fp32_asm_pkg::EXP_MAX, 23'd0};
		else if (inf_b)
			r.bits = {sb, fp32_asm_pkg::EXP_MAX, 23'd0};
		else if (zero_a && zero_b)
			r.bits = {sa & sb, 31'd0};
		else if (zero_b)
			r.bits = {sa, a[30:0]};
		else if (zero_a)
			r.bits = {sb, b[30:0]};
		else begin
			sx = sa; ex = ea; mx = {1'b1, a[22:0]};
			sy = sb; ey = eb; my = {1'b1, b[22:0]};
			if (ex < ey || (ex == ey && mx < my)) begin
				t = sx; sx = sy; sy = t;
				te = ex; ex = ey; ey = te;
				tm = mx; mx = my; my = tm;
			end
			d = ex - ey;
			big = 64'(mx) << 30;
			sml = 64'(my) << 30;
			if (d >= 60)
				sml = 64'd1;
			else if (d > 0) begin
				lost = sml & ((64'd1 << d) - 64'd1);
				sml = sml >> d;
				if (lost != 0)
					sml[0] = 1'b1;
			end
			sum = (sx == sy) ? big + sml : big - sml;
			if (sum == 0)
				r.bits = 32'd0;
			else
				r = normalize(sx, int'(ex), sum, 53);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		fp_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_results.push_back(fp_compute(op, operand_a, operand_b));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected transfer", result_bits, 32'd0);
				else begin
					want = expected_results.pop_front();
					if (result_bits !== want.bits)
						report_mismatch("result_bits", result_bits, want.bits);
					if (overflow !== want.ovf)
						report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
					if (underflow !== want.unf)
						report_mismatch("underflow", 32'(underflow), 32'(want.unf));
				end
			end
		end
		pending = expected_results.size();
	end
endmodule

// ===== bench/tb_fp32_add_sub_mul_unit_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fp32_add_sub_mul_unit_top
// Drives directed and random add, subtract and multiply operations into the
// unit with bursty input and a stalling receiver, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_fp32_add_sub_mul_unit_top;
	localparam int RANDOM_OPS = 1430;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result_bits;
	logic        overflow;
	logic        underflow;
	int          fail_count;
	int          pending;
	logic        hold_off;

	fp32_add_sub_mul_unit_top uut (.*);

	fp32_add_sub_mul_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [31:0] rand_operand();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[30:23] = 8'd0;
			1: v[30:23] = fp32_asm_pkg::EXP_MAX;
			2: v[30:0] = {fp32_asm_pkg::EXP_MAX, 23'd0};
			3: v[30:23] = 8'($urandom_range(1, 6));
			4: v[30:23] = 8'($urandom_range(249, 254));
			default: v[30:23] = 8'($urandom_range(100, 154));
		endcase
		return v;
	endfunction

	task automatic send_op(logic [1:0] code, logic [31:0] a, logic [31:0] b);
		op <= code;
		operand_a <= a;
		operand_b <= b;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_near(logic [1:0] code);
		logic [31:0] a, b;
		a = rand_operand();
		b = a ^ 32'($urandom_range(0, 15));
		b[30:23] = a[30:23] - 8'($urandom_range(0, 2));
		if ($urandom_range(0, 1))
			b[31] = ~a[31];
		send_op(code, a, b);
	endtask

	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 3) != 0) || (($time % 4000) < 1200);
	end

	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		#2400;
		@(negedge clk);
		hold_off = 1'b1;
		repeat (60) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int sent;
		int burst;
		int gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = fp32_asm_pkg::OP_ADD;
		operand_a = '0;
		operand_b = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_op(fp32_asm_pkg::OP_ADD, 32'h3F800000, 32'h3F800000);
		send_op(fp32_asm_pkg::OP_SUB, 32'h3F800000, 32'h3F800000);
		send_op(fp32_asm_pkg::OP_MUL, 32'h40400000, 32'hC0000000);
		send_op(fp32_asm_pkg::OP_MUL_ALT, 32'h3FC00000, 32'h3FC00000);
		send_op(fp32_asm_pkg::OP_ADD, 32'h00400000, 32'h3F800000);
		send_op(fp32_asm_pkg::OP_ADD, 32'h00000000, 32'h80000000);
		send_op(fp32_asm_pkg::OP_ADD, 32'h80000000, 32'h80000000);
		send_op(fp32_asm_pkg::OP_SUB, 32'h80000000, 32'h00000000);
		send_op(fp32_asm_pkg::OP_MUL, 32'h00000000, 32'hC1200000);
		send_op(fp32_asm_pkg::OP_ADD, 32'h7FC00001, 32'h3F800000);
		send_op(fp32_asm_pkg::OP_MUL, 32'h3F800000, 32'hFFFFFFFF);
		send_op(fp32_asm_pkg::OP_SUB, 32'h7F800000, 32'h7F800000);
		send_op(fp32_asm_pkg::OP_ADD, 32'h7F800000, 32'hFF800000);
		send_op(fp32_asm_pkg::OP_MUL, 32'h7F800000, 32'h00000000);
		send_op(fp32_asm_pkg::OP_MUL, 32'hFF800000, 32'h3F800000);
		send_op(fp32_asm_pkg::OP_ADD, 32'h3F800000, 32'hFF800000);
		send_op(fp32_asm_pkg::OP_ADD, 32'h7F7FFFFF, 32'h7F7FFFFF);
		send_op(fp32_asm_pkg::OP_MUL, 32'h7F7FFFFF, 32'h7F7FFFFF);
		send_op(fp32_asm_pkg::OP_MUL, 32'h00800000, 32'h00800000);
		send_op(fp32_asm_pkg::OP_SUB, 32'h00800001, 32'h00800000);
		send_op(fp32_asm_pkg::OP_ADD, 32'h7F7FFFFF, 32'h00800000);
		send_op(fp32_asm_pkg::OP_SUB, 32'h3F800001, 32'h3F800000);
		send_op(fp32_asm_pkg::OP_MUL, 32'h3F7FFFFF, 32'h3F7FFFFF);
		send_op(fp32_asm_pkg::OP_ADD, 32'hFFFFFFFF, 32'h00000000);
		sent = 0;
		while (sent < RANDOM_OPS) begin
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				if ($urandom_range(0, 4) == 0)
					send_near(2'($urandom_range(0, 1)));
				else
					send_op(2'($urandom_range(0, 3)), rand_operand(), rand_operand());
				sent++;
			end
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== fp32_add_sub_mul_unit_top.f =====
design/fp32_asm_pkg.sv
design/fp32_add_sub_mul_unit_top.sv
bench/fp32_add_sub_mul_checker.sv
bench/tb_fp32_add_sub_mul_unit_top.sv
